// ----- rtl/daily_time_window_table_top_defines.svh -----
// Assertion macros used by the time window table controller.
`ifndef DAILY_TIME_WINDOW_TABLE_TOP_DEFINES_SVH
`define DAILY_TIME_WINDOW_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checks a property on every clock edge outside reset.
`define DTWT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define DTWT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define DTWT_ASSERT(name, clk, rst_n, prop, msg)
`define DTWT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/dtwt_pkg.sv -----
// Types, constants and helper functions of the daily time window table.
package dtwt_pkg;

  localparam int unsigned NUM_WINDOWS_DEF = 4;

  localparam logic [4:0]  HOUR_MAX      = 5'd23;
  localparam logic [5:0]  MINUTE_MAX    = 6'd59;
  localparam logic [10:0] MIN_PER_HOUR  = 11'd60;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] entry_index;
    logic [4:0] on_hour;
    logic [5:0] on_minute;
    logic [4:0] off_hour;
    logic [5:0] off_minute;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } in_req_t;

  typedef struct packed {
    logic       active;
    logic [4:0] read_on_hour;
    logic [5:0] read_on_minute;
    logic [4:0] read_off_hour;
    logic [5:0] read_off_minute;
  } out_rsp_t;

  typedef struct packed {
    logic [4:0] on_hour;
    logic [5:0] on_minute;
    logic [4:0] off_hour;
    logic [5:0] off_minute;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic ram_we;
    logic ram_re;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [4:0] clamp_hour(input logic [4:0] h);
    return (h > HOUR_MAX) ? HOUR_MAX : h;
  endfunction

  function automatic logic [5:0] clamp_minute(input logic [5:0] m);
    return (m > MINUTE_MAX) ? MINUTE_MAX : m;
  endfunction

  // 31 * 60 + 63 still fits in eleven bits.
  function automatic logic [10:0] minutes_of_day(input logic [4:0] h, input logic [5:0] m);
    return 11'(11'(h) * MIN_PER_HOUR) + 11'(m);
  endfunction

endpackage

// ----- rtl/daily_time_window_table_top.sv -----
// Top level of the daily time window table.
//
// The block keeps NUM_WINDOWS daily on/off windows, all cleared (disabled) by reset.
// Requests arrive on the in_valid_i / in_stall_o channel with an in_req_t payload;
// a request is taken at a clock edge where in_valid_i is high and in_stall_o is low.
// Each request yields exactly one response on out_valid_o / out_stall_i.
// A write stores one clamped entry, a read returns one entry, and a check reports
// whether any enabled window contains the current hour and minute. Code 3 returns
// an all-zero response and leaves the table unchanged.
// A write, read or unused code passes through the execute and finish states, and its
// response is loaded into the output register in the finish state. A check walks the
// window memory one entry per cycle through its single read port in the scan state,
// then loads its response into the output register in the finish state.
// One request is in service at a time; in_stall_o is high while it is processed.
// A finished response sits in an output register, so the next request can be taken
// while the receiver still stalls. If the output register is full when another
// response is ready, the block waits with that response until the slot frees.
// Reset is asynchronous and active low; it clears all valid bits, so no clearing
// pass is needed and the block accepts requests in the first cycle after reset.
module daily_time_window_table_top import dtwt_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  // Command and status between the sequencer and the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  dtwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the request, the window memory and the response register.
  dtwt_dp #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ----- rtl/dtwt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module dtwt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dtwt_ctrl.sv -----
// Controller state machine that sequences writes, reads and window checks.
`include "daily_time_window_table_top_defines.svh"

module dtwt_ctrl import dtwt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        unique case (status_i.op)
          OP_WRITE: cmd_o.ram_we = 1'b1;
          OP_READ:  cmd_o.ram_re = 1'b1;
          OP_CHECK: begin
            cmd_o.ram_re     = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.ram_re    = !status_i.scan_last;
        if (status_i.scan_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `DTWT_ASSERT(a_accept_exec, clk_i, rst_ni, (in_valid_i && state_q == S_IDLE) |=> (state_q == S_EXEC), "accepted request did not start execution")
  `DTWT_ASSERT(a_scan_end, clk_i, rst_ni, (state_q == S_SCAN && status_i.scan_last) |=> (state_q == S_FIN), "scan did not finish after the last entry")
  `DTWT_ASSERT(a_hold_result, clk_i, rst_ni, (state_q == S_FIN && !status_i.out_free) |=> (state_q == S_FIN), "pending result dropped while output was full")
  `DTWT_ASSERT_IMP(a_write_only_exec, clk_i, rst_ni, cmd_o.ram_we, (state_q == S_EXEC && status_i.op == OP_WRITE), "table written outside a write request")

endmodule

// ----- rtl/dtwt_dp.sv -----
// Datapath: request registers, window storage, scan logic and output register.
module dtwt_dp import dtwt_pkg::*; #(
  parameter int unsigned NUM_WINDOWS = NUM_WINDOWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_req_t    in_req_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_rsp_t   out_rsp_o
);

  localparam int unsigned IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
  // The index field is two bits, so only table sizes below four need a reduction.
  localparam logic [2:0] MOD_N = (NUM_WINDOWS > 4) ? 3'd4 : 3'(NUM_WINDOWS);

  op_e              op_q;
  logic [IDX_W-1:0] idx_q;
  entry_t           wentry_q;
  logic [10:0]      now_q;
  logic [IDX_W-1:0] cnt_q;
  logic             any_q;
  logic [NUM_WINDOWS-1:0] valid_q;
  logic             out_valid_q;
  out_rsp_t         out_q;

  logic [1:0]       idx_rem;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           rd_entry;
  logic [10:0]      on_t;
  logic [10:0]      off_t;
  logic             hit;
  logic             scan_last;
  out_rsp_t         out_d;

  // Index modulo the table size by repeated compare and subtract.
  always_comb begin
    idx_rem = in_req_i.entry_index;
    for (int k = 0; k < 3; k++) begin
      if ({1'b0, idx_rem} >= MOD_N) begin
        idx_rem = 2'({1'b0, idx_rem} - MOD_N);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q                <= op_e'(in_req_i.operation);
      idx_q               <= IDX_W'(idx_rem);
      wentry_q.on_hour    <= clamp_hour(in_req_i.on_hour);
      wentry_q.on_minute  <= clamp_minute(in_req_i.on_minute);
      wentry_q.off_hour   <= clamp_hour(in_req_i.off_hour);
      wentry_q.off_minute <= clamp_minute(in_req_i.off_minute);
      now_q               <= minutes_of_day(in_req_i.now_hour, in_req_i.now_minute);
    end
  end

  always_comb begin
    if (cmd_i.scan_start) begin
      ram_raddr = '0;
    end else if (cmd_i.scan_step) begin
      ram_raddr = cnt_q + IDX_W'(1);
    end else begin
      ram_raddr = idx_q;
    end
  end

  dtwt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_WINDOWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx_q),
    .wdata_i (wentry_q),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Window test for the entry read in the previous cycle.
  always_comb begin
    on_t  = minutes_of_day(rd_entry.on_hour, rd_entry.on_minute);
    off_t = minutes_of_day(rd_entry.off_hour, rd_entry.off_minute);
    hit   = 1'b0;
    if (valid_q[cnt_q] && (on_t != off_t)) begin
      if (on_t < off_t) begin
        hit = (now_q >= on_t) && (now_q < off_t);
      end else begin
        hit = (now_q >= on_t) || (now_q < off_t);
      end
    end
  end

  assign scan_last = (cnt_q == IDX_W'(NUM_WINDOWS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      any_q   <= 1'b0;
      valid_q <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
        any_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        any_q <= any_q | hit;
        if (!scan_last) begin
          cnt_q <= cnt_q + IDX_W'(1);
        end
      end
      if (cmd_i.ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_comb begin
    out_d = '0;
    unique case (op_q)
      OP_READ: begin
        if (valid_q[idx_q]) begin
          out_d.read_on_hour    = rd_entry.on_hour;
          out_d.read_on_minute  = rd_entry.on_minute;
          out_d.read_off_hour   = rd_entry.off_hour;
          out_d.read_off_minute = rd_entry.off_minute;
        end
      end
      OP_CHECK: out_d.active = any_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign status_o.op        = op_q;
  assign status_o.scan_last = scan_last;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign out_rsp_o          = out_q;

endmodule
